// ===== rtl/v2a_pkg.sv =====
`default_nettype none
package v2a_pkg;

    localparam int FRAC_BITS = 16;

    localparam int ROOT_W = 32;            // root of a sum of two 32-bit squares
    localparam int REM_W  = ROOT_W + 3;    // shifted remainder of the root step
    localparam int QUO_W  = FRAC_BITS + 1; // |a| <= len, so q <= 2^FRAC_BITS

    localparam logic [2:0] FUNC_ADD  = 3'd0;
    localparam logic [2:0] FUNC_SUB  = 3'd1;
    localparam logic [2:0] FUNC_SCL  = 3'd2;
    localparam logic [2:0] FUNC_NORM = 3'd3;
    localparam logic [2:0] FUNC_LEN  = 3'd4;

    // item context carried beside the root and divide pipes
    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic [15:0]        magnitude;
        logic               sat;
        logic               zero;
    } side_t;

    // {clipped, value}
    function automatic logic [32:0] clip32(input logic signed [63:0] v);
        logic [32:0] res;
        if (v[63:31] == {33{v[63]}})
            res = {1'b0, v[31:0]};
        else if (v[63])
            res = {1'b1, 32'h8000_0000};
        else
            res = {1'b1, 32'h7FFF_FFFF};
        return res;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic [31:0] res;
        res = v[31] ? (~v + 32'd1) : v;
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/v2a_front.sv =====
`default_nettype none
module v2a_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               in_vld,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] ax,
    input  wire logic signed [31:0] ay,
    input  wire logic signed [31:0] bx,
    input  wire logic signed [31:0] by,
    input  wire logic signed [31:0] factor,
    output logic                    out_vld,
    output logic [63:0]             sum_sq,
    output v2a_pkg::side_t          side
);
    import v2a_pkg::*;

    // stage 1: multiplies and add/sub
    logic               v1_reg;
    logic [2:0]         func1_reg;
    logic signed [31:0] ax1_reg, ay1_reg;
    logic [63:0]        sqx1_reg, sqy1_reg;
    logic signed [63:0] px1_reg, py1_reg;
    logic signed [32:0] sx1_reg, sy1_reg;

    logic [31:0] magx, magy;
    logic signed [32:0] ax33, ay33, bx33, by33;

    assign magx = mag32(ax);
    assign magy = mag32(ay);
    assign ax33 = {ax[31], ax};
    assign ay33 = {ay[31], ay};
    assign bx33 = {bx[31], bx};
    assign by33 = {by[31], by};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg <= func;
            ax1_reg   <= ax;
            ay1_reg   <= ay;
            sqx1_reg  <= 64'(magx) * 64'(magx);
            sqy1_reg  <= 64'(magy) * 64'(magy);
            px1_reg   <= ax * factor;
            py1_reg   <= ay * factor;
            sx1_reg   <= (func == FUNC_SUB) ? ax33 - bx33 : ax33 + bx33;
            sy1_reg   <= (func == FUNC_SUB) ? ay33 - by33 : ay33 + by33;
        end
    end

    // stage 2: sum of squares, scale shift, clipping
    logic        v2_reg;
    logic [63:0] s2_reg;
    side_t       side2_reg;
    side_t       side_next;

    logic signed [63:0] qx, qy;
    logic [32:0] cx, cy;

    assign qx = px1_reg >>> FRAC_BITS;
    assign qy = py1_reg >>> FRAC_BITS;

    always_comb
    begin
        cx = '0;
        cy = '0;
        case (func1_reg)
            FUNC_ADD, FUNC_SUB:
            begin
                cx = clip32(64'(sx1_reg));
                cy = clip32(64'(sy1_reg));
            end
            FUNC_SCL:
            begin
                cx = clip32(qx);
                cy = clip32(qy);
            end
            default:
            begin
                cx = '0;
                cy = '0;
            end
        endcase
        side_next.func      = func1_reg;
        side_next.ax        = ax1_reg;
        side_next.ay        = ay1_reg;
        side_next.rx        = cx[31:0];
        side_next.ry        = cy[31:0];
        side_next.magnitude = '0;
        side_next.sat       = cx[32] | cy[32];
        side_next.zero      = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg    <= sqx1_reg + sqy1_reg;
            side2_reg <= side_next;
        end
    end

    assign out_vld = v2_reg;
    assign sum_sq  = s2_reg;
    assign side    = side2_reg;

endmodule
`default_nettype wire

// ===== rtl/v2a_sqrt.sv =====
`default_nettype none
module v2a_sqrt (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire logic [63:0]    sum_sq,
    input  wire v2a_pkg::side_t side_in,
    output logic                out_vld,
    output logic [31:0]         root,
    output v2a_pkg::side_t      side_out
);
    import v2a_pkg::*;

    // one root bit per stage, two radicand bits consumed per stage
    logic              vld_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [63:0]       s_reg    [ROOT_W];
    side_t             side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic              v_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial;
        logic [ROOT_W-1:0] root_in;
        logic [63:0]       s_in;
        side_t             side_i;

        if (k == 0)
        begin : g_first
            assign v_in    = in_vld;
            assign rem_in  = '0;
            assign root_in = '0;
            assign s_in    = sum_sq;
            assign side_i  = side_in;
        end
        else
        begin : g_next
            assign v_in    = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign s_in    = s_reg[k-1];
            assign side_i  = side_reg[k-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], s_in[63:62]};
        assign trial  = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg[k]  <= rem_sh - trial;
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_sh;
                    root_reg[k] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                s_reg[k]    <= {s_in[61:0], 2'b00};
                side_reg[k] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/v2a_div.sv =====
`default_nettype none
module v2a_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_vld,
    input  wire logic [31:0]       len,
    input  wire v2a_pkg::side_t    side_in,
    output logic                   out_vld,
    output logic [v2a_pkg::QUO_W-1:0] qx,
    output logic [v2a_pkg::QUO_W-1:0] qy,
    output v2a_pkg::side_t         side_out
);
    import v2a_pkg::*;

    // restoring divide of (|a| << FRAC_BITS) by len, x and y lanes side by side;
    // |a| <= len keeps every partial remainder below len
    logic             vld_reg  [QUO_W];
    logic [31:0]      len_reg  [QUO_W];
    logic [31:0]      rx_reg   [QUO_W];
    logic [31:0]      ry_reg   [QUO_W];
    logic [QUO_W-1:0] qx_reg   [QUO_W];
    logic [QUO_W-1:0] qy_reg   [QUO_W];
    side_t            side_reg [QUO_W];

    logic [31:0] magx, magy;
    assign magx = mag32(side_in.ax);
    assign magy = mag32(side_in.ay);

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic             v_in;
        logic [31:0]      len_in;
        logic [32:0]      shx, shy, dvs;
        logic [QUO_W-1:0] qx_in, qy_in;
        side_t            side_i;

        if (k == 0)
        begin : g_first
            assign v_in   = in_vld;
            assign len_in = len;
            assign shx    = {1'b0, magx};
            assign shy    = {1'b0, magy};
            assign qx_in  = '0;
            assign qy_in  = '0;
            assign side_i = side_in;
        end
        else
        begin : g_next
            assign v_in   = vld_reg[k-1];
            assign len_in = len_reg[k-1];
            assign shx    = {rx_reg[k-1], 1'b0};
            assign shy    = {ry_reg[k-1], 1'b0};
            assign qx_in  = qx_reg[k-1];
            assign qy_in  = qy_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign dvs = {1'b0, len_in};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (shx >= dvs)
                begin
                    rx_reg[k] <= 32'(shx - dvs);
                    qx_reg[k] <= {qx_in[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rx_reg[k] <= shx[31:0];
                    qx_reg[k] <= {qx_in[QUO_W-2:0], 1'b0};
                end
                if (shy >= dvs)
                begin
                    ry_reg[k] <= 32'(shy - dvs);
                    qy_reg[k] <= {qy_in[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    ry_reg[k] <= shy[31:0];
                    qy_reg[k] <= {qy_in[QUO_W-2:0], 1'b0};
                end
                len_reg[k]  <= len_in;
                side_reg[k] <= side_i;
            end
        end
    end

    assign out_vld  = vld_reg[QUO_W-1];
    assign qx       = qx_reg[QUO_W-1];
    assign qy       = qy_reg[QUO_W-1];
    assign side_out = side_reg[QUO_W-1];

endmodule
`default_nettype wire

// ===== rtl/vector2_alu.sv =====
`default_nettype none
// vector2_alu: 2-D vector unit on signed Q16.16 coordinates (func: add, subtract,
// scale, normalize, length). Fully pipelined: one beat accepted per cycle while
// in_stall is low. Every beat gives one result beat after passing the front, the
// 32-stage square root (one root bit a stage), the 17-stage restoring divider
// (one quotient bit a stage) and the output register. The whole pipe moves
// on one enable; it holds only while a result waits at the output and out_stall
// is high, so in_stall is that same condition. No state, no reset-time sweep.
module vector2_alu (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         func,
    input  wire logic signed [31:0] ax,
    input  wire logic signed [31:0] ay,
    input  wire logic signed [31:0] bx,
    input  wire logic signed [31:0] by,
    input  wire logic signed [31:0] factor,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      rx,
    output logic signed [31:0]      ry,
    output logic [15:0]             magnitude,
    output logic                    saturated,
    output logic                    zero_vector
);
    import v2a_pkg::*;

    logic en;

    // front: multiplies, then sum of squares and add/sub/scale results
    logic        f_vld;
    logic [63:0] f_sum;
    side_t       f_side;

    // square root
    logic        r_vld;
    logic [31:0] r_len;
    side_t       r_side;
    side_t       d_side_in;

    // divider
    logic             d_vld;
    logic [QUO_W-1:0] d_qx, d_qy;

    // output register
    logic               out_vld_reg;
    logic signed [31:0] rx_reg, ry_reg, rx_next, ry_next;
    logic [15:0]        mag_reg;
    logic               sat_reg, zero_reg;

    // advance unless a finished beat is held at the output
    assign en       = !out_vld_reg || !out_stall;
    assign in_stall = !en;

    v2a_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .func    (func),
        .ax      (ax),
        .ay      (ay),
        .bx      (bx),
        .by      (by),
        .factor  (factor),
        .out_vld (f_vld),
        .sum_sq  (f_sum),
        .side    (f_side)
    );

    v2a_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .sum_sq   (f_sum),
        .side_in  (f_side),
        .out_vld  (r_vld),
        .root     (r_len),
        .side_out (r_side)
    );

    // length result and zero check are settled here, ride the divider as context
    logic big;
    assign big = (r_len >> (FRAC_BITS + 16)) != '0;

    always_comb
    begin
        d_side_in = r_side;
        if (r_side.func == FUNC_LEN)
        begin
            d_side_in.magnitude = big ? 16'hFFFF : 16'(r_len >> FRAC_BITS);
            d_side_in.sat       = big;
        end
        d_side_in.zero = (r_side.func == FUNC_NORM) && (r_len == '0);
    end

    side_t div_side_out;

    v2a_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (r_vld),
        .len      (r_len),
        .side_in  (d_side_in),
        .out_vld  (d_vld),
        .qx       (d_qx),
        .qy       (d_qy),
        .side_out (div_side_out)
    );

    // normalize: apply the coordinate sign to the quotient; zero vector gives zeros
    logic [31:0] ux, uy;
    assign ux = 32'(d_qx);
    assign uy = 32'(d_qy);

    always_comb
    begin
        rx_next = div_side_out.rx;
        ry_next = div_side_out.ry;
        if (div_side_out.func == FUNC_NORM)
        begin
            if (div_side_out.zero)
            begin
                rx_next = '0;
                ry_next = '0;
            end
            else
            begin
                rx_next = div_side_out.ax[31] ? -ux : ux;
                ry_next = div_side_out.ay[31] ? -uy : uy;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            mag_reg  <= div_side_out.magnitude;
            sat_reg  <= div_side_out.sat;
            zero_reg <= div_side_out.zero;
        end
    end

    assign out_valid   = out_vld_reg;
    assign rx          = rx_reg;
    assign ry          = ry_reg;
    assign magnitude   = mag_reg;
    assign saturated   = sat_reg;
    assign zero_vector = zero_reg;

endmodule
`default_nettype wire
